// ----- hdl/asc_pkg.sv -----
// Shared types and constants for the area-average image scaler.
package asc_pkg;

   localparam int MaxChannels = 4;
   localparam int ResultCap   = 16;

   localparam logic [3:0] REG_IN_WIDTH     = 4'd0;
   localparam logic [3:0] REG_IN_HEIGHT    = 4'd1;
   localparam logic [3:0] REG_OUT_WIDTH    = 4'd2;
   localparam logic [3:0] REG_OUT_HEIGHT   = 4'd3;
   localparam logic [3:0] REG_CHANNELS     = 4'd4;
   localparam logic [3:0] REG_MONO_MODE    = 4'd5;
   localparam logic [3:0] REG_DIVISOR      = 4'd6;
   localparam logic [3:0] REG_WEIGHT_SHIFT = 4'd7;

   typedef logic [MaxChannels-1:0][31:0] acc_row_type;
   typedef logic [MaxChannels-1:0][7:0]  byte_row_type;

   typedef struct packed {
      byte_row_type ch;
      logic [9:0]   column;
      logic [11:0]  row;
      logic         row_end;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_STEP,
      ST_MAC,
      ST_ADD,
      ST_DIV,
      ST_EMIT,
      ST_FINISH
   } state_type;

endpackage

// ----- hdl/asc_acc_mem.sv -----
// Accumulator memory: one row of channel accumulators per output column.
module asc_acc_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output asc_pkg::acc_row_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  asc_pkg::acc_row_type wr_data
);
   import asc_pkg::*;

   acc_row_type mem [DEPTH];
   acc_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/asc_div.sv -----
// Four-lane restoring divider, one quotient bit per cycle.
module asc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  asc_pkg::acc_row_type  dividend,
   input  logic [23:0]           divisor,
   output logic                  done,
   output asc_pkg::byte_row_type quotient
);
   import asc_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [5:0]                  cnt_ff, cnt_in;
   acc_row_type                 quo_ff, quo_in;
   logic [MaxChannels-1:0][23:0] rem_ff, rem_in;
   logic [24:0]                 trial;
   logic                        ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = '0;
      ge      = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int c = 0; c < MaxChannels; c++) begin
            trial = {rem_ff[c], quo_ff[c][31]};
            ge = trial >= {1'b0, divisor};
            rem_in[c] = ge ? 24'(trial - {1'b0, divisor}) : trial[23:0];
            quo_in[c] = {quo_ff[c][30:0], ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      for (int c = 0; c < MaxChannels; c++) begin
         quotient[c] = quo_ff[c][7:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- hdl/area_average_image_scaler.sv -----
// Area-average image scaler: pixels stream in raster order; each input pixel
// passes through a setup, step and finish state; each output column that it
// completes adds a multiply and an add state, plus, on a boundary row, a divide
// and an emit state, where the 32-step divider produces the output pixel; a
// stalled output side adds its stall. The accumulators sit in one memory row
// per output column, read and written back once per completed column. After
// reset and after every configuration write the block sweeps every address of
// that memory to zero, accepting no pixel meanwhile. The next pixel is taken
// while the last output pixel still waits in the output register.
module area_average_image_scaler #(
   parameter int MAX_OUT_WIDTH = 1024,
   parameter int MAX_UPSCALE   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_ch0,
   input  logic [7:0]  req_in_ch1,
   input  logic [7:0]  req_in_ch2,
   input  logic [7:0]  req_in_ch3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_ch0,
   output logic [7:0]  rsp_out_ch1,
   output logic [7:0]  rsp_out_ch2,
   output logic [7:0]  rsp_out_ch3,
   output logic [9:0]  rsp_out_column,
   output logic [11:0] rsp_out_row,
   output logic        rsp_row_end,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [23:0] csr_data
);
   import asc_pkg::*;

   localparam int AW = $clog2(MAX_OUT_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_OUT_WIDTH - 1);
   localparam logic [6:0] UP_LIM = 7'((MAX_UPSCALE < ResultCap) ? MAX_UPSCALE : ResultCap);
   localparam logic [12:0] MAX_OW = 13'(MAX_OUT_WIDTH);
   localparam logic [4:0] RES_CAP = 5'(ResultCap);

   state_type state_ff, state_in;

   logic [10:0] in_width_ff, in_width_in;
   logic [11:0] in_height_ff, in_height_in;
   logic [10:0] out_width_ff, out_width_in;
   logic [11:0] out_height_ff, out_height_in;
   logic [2:0]  channels_ff, channels_in;
   logic        mono_ff, mono_in;
   logic [23:0] divisor_ff, divisor_in;
   logic [3:0]  shift_ff, shift_in;

   logic [12:0] vp_ff, vp_in;
   logic [10:0] hph_ff, hph_in;
   logic [9:0]  icol_ff, icol_in;
   logic [10:0] ocol_ff, ocol_in;
   logic [11:0] orow_ff, orow_in;
   logic        bnd_ff, bnd_in;
   logic [10:0] rem_ff, rem_in;
   logic [4:0]  n_ff, n_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        pend_v_ff, pend_v_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [MaxChannels-1:0][17:0] cs_ff, cs_in;

   byte_row_type v_ff, v_in;
   logic [11:0]  wu_ff, wu_in, wl_ff, wl_in;
   acc_row_type  pu_ff, pu_in, pl_ff, pl_in;
   result_type   pend_ff, pend_in, rsp_ff, rsp_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [10:0] iw_eff, ow0, ow1, ow_eff;
   logic [11:0] oh_eff, ih0, ih_eff;
   logic [17:0] lim;
   logic [2:0]  nch;
   logic [23:0] div_eff;

   logic        cfg_hit, accept, active, col_done, emit_now, can_push, go;
   logic [10:0] room, take, hph_new;
   logic [12:0] vp_sum;
   logic        row_bnd;
   logic [11:0] wu_raw, wl_raw;
   acc_row_type sum;
   byte_row_type in_bytes;

   logic        rd_en, wr_en, div_start, div_done;
   logic [AW-1:0] wr_addr;
   acc_row_type rd_data, wr_data;
   byte_row_type quotient;

   function automatic logic [11:0] shrink(input logic [11:0] w, input logic [3:0] s);
      logic [16:0] t;
      t = 17'(w) + (17'(1) << s) - 17'(1);
      return 12'(t >> s);
   endfunction

   assign iw_eff  = (in_width_ff == '0) ? 11'd1 : in_width_ff;
   assign oh_eff  = (out_height_ff == '0) ? 12'd1 : out_height_ff;
   assign ih0     = (in_height_ff == '0) ? 12'd1 : in_height_ff;
   assign ih_eff  = (ih0 < oh_eff) ? oh_eff : ih0;
   assign ow0     = (out_width_ff == '0) ? 11'd1 : out_width_ff;
   assign ow1     = ({2'b0, ow0} > MAX_OW) ? MAX_OW[10:0] : ow0;
   assign lim     = 18'(UP_LIM) * 18'(iw_eff);
   assign ow_eff  = (18'(ow1) > lim) ? lim[10:0] : ow1;
   assign div_eff = (divisor_ff == '0) ? 24'd1 : divisor_ff;
   always_comb begin
      if (mono_ff || channels_ff == 3'd1) begin
         nch = 3'd1;
      end else if (channels_ff == 3'd3) begin
         nch = 3'd3;
      end else begin
         nch = 3'd4;
      end
   end

   assign cfg_hit   = csr_valid && (csr_index <= REG_WEIGHT_SHIFT);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign in_bytes  = {req_in_ch3, req_in_ch2, req_in_ch1, req_in_ch0};

   assign active   = (rem_ff != '0) && (ocol_ff < ow_eff);
   assign room     = iw_eff - hph_ff;
   assign take     = (room < rem_ff) ? room : rem_ff;
   assign hph_new  = hph_ff + take;
   assign col_done = hph_new >= iw_eff;
   assign emit_now = bnd_ff && (n_ff < RES_CAP);
   assign can_push = !rsp_valid_ff || rsp_ready;
   assign go       = !pend_v_ff || can_push;

   assign vp_sum  = vp_ff + 13'(oh_eff);
   assign row_bnd = vp_sum >= 13'(ih_eff);
   assign wu_raw  = row_bnd ? 12'(13'(ih_eff) + 13'(oh_eff) - vp_sum) : oh_eff;
   assign wl_raw  = row_bnd ? 12'(vp_sum - 13'(ih_eff)) : 12'd0;

   always_comb begin
      for (int c = 0; c < MaxChannels; c++) begin
         sum[c] = rd_data[c] + pu_ff[c];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_STEP;
         ST_STEP: begin
            if (!active) begin
               state_in = ST_FINISH;
            end else if (col_done) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: state_in = ST_ADD;
         ST_ADD: state_in = emit_now ? ST_DIV : ST_STEP;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (go) begin
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (cfg_hit) begin
         state_in = ST_CLEAR;
      end
   end

   // datapath and outputs
   always_comb begin
      in_width_in   = in_width_ff;
      in_height_in  = in_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      channels_in   = channels_ff;
      mono_in       = mono_ff;
      divisor_in    = divisor_ff;
      shift_in      = shift_ff;
      vp_in         = vp_ff;
      hph_in        = hph_ff;
      icol_in       = icol_ff;
      ocol_in       = ocol_ff;
      orow_in       = orow_ff;
      bnd_in        = bnd_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      pend_v_in     = pend_v_ff;
      cs_in         = cs_ff;
      v_in          = v_ff;
      wu_in         = wu_ff;
      wl_in         = wl_ff;
      pu_in         = pu_ff;
      pl_in         = pl_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = AW'(ocol_ff);
      wr_data       = '0;
      div_start     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               for (int c = 0; c < MaxChannels; c++) begin
                  v_in[c] = (3'(c) < nch) ? in_bytes[c] : 8'd0;
               end
               if (mono_ff) begin
                  v_in[0] = {7'd0, (req_in_ch0 != 8'd0)};
               end
               rem_in = ow_eff;
               n_in   = '0;
            end
         end
         ST_SETUP: begin
            if (icol_ff == '0) begin
               bnd_in = row_bnd;
               vp_in  = row_bnd ? vp_sum - 13'(ih_eff) : vp_sum;
               wu_in  = shrink(wu_raw, shift_ff);
               wl_in  = shrink(wl_raw, shift_ff);
            end
         end
         ST_STEP: begin
            if (active) begin
               for (int c = 0; c < MaxChannels; c++) begin
                  cs_in[c] = cs_ff[c] + 18'(take) * 18'(v_ff[c]);
               end
               hph_in = hph_new;
               rem_in = rem_ff - take;
               rd_en  = col_done;
            end
         end
         ST_MAC: begin
            for (int c = 0; c < MaxChannels; c++) begin
               pu_in[c] = 32'(wu_ff) * 32'(cs_ff[c]);
               pl_in[c] = 32'(wl_ff) * 32'(cs_ff[c]);
            end
         end
         ST_ADD: begin
            if (emit_now) begin
               div_start = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_data = sum;
               cs_in   = '0;
               hph_in  = '0;
               ocol_in = ocol_ff + 11'd1;
            end
         end
         ST_EMIT: begin
            if (go) begin
               if (pend_v_ff) begin
                  rsp_in       = pend_ff;
                  rsp_last_in  = 1'b0;
                  rsp_valid_in = 1'b1;
               end
               pend_v_in       = 1'b1;
               pend_in.ch      = quotient;
               pend_in.column  = ocol_ff[9:0];
               pend_in.row     = orow_ff;
               pend_in.row_end = (ocol_ff + 11'd1 == ow_eff);
               wr_en   = 1'b1;
               wr_data = pl_ff;
               n_in    = n_ff + 5'd1;
               cs_in   = '0;
               hph_in  = '0;
               ocol_in = ocol_ff + 11'd1;
            end
         end
         ST_FINISH: begin
            if (go) begin
               if (pend_v_ff) begin
                  rsp_in       = pend_ff;
                  rsp_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               pend_v_in = 1'b0;
               if (11'(icol_ff) + 11'd1 >= iw_eff) begin
                  icol_in = '0;
                  ocol_in = '0;
                  hph_in  = '0;
                  cs_in   = '0;
                  if (bnd_ff) begin
                     if (orow_ff + 12'd1 >= oh_eff) begin
                        orow_in = '0;
                        vp_in   = '0;
                     end else begin
                        orow_in = orow_ff + 12'd1;
                     end
                  end
               end else begin
                  icol_in = icol_ff + 10'd1;
               end
            end
         end
         default: begin
         end
      endcase

      if (cfg_hit) begin
         case (csr_index)
            REG_IN_WIDTH:     in_width_in   = csr_data[10:0];
            REG_IN_HEIGHT:    in_height_in  = csr_data[11:0];
            REG_OUT_WIDTH:    out_width_in  = csr_data[10:0];
            REG_OUT_HEIGHT:   out_height_in = csr_data[11:0];
            REG_CHANNELS:     channels_in   = csr_data[2:0];
            REG_MONO_MODE:    mono_in       = csr_data[0];
            REG_DIVISOR:      divisor_in    = csr_data;
            REG_WEIGHT_SHIFT: shift_in      = csr_data[3:0];
            default: begin
            end
         endcase
         vp_in   = '0;
         hph_in  = '0;
         icol_in = '0;
         ocol_in = '0;
         orow_in = '0;
         bnd_in  = 1'b0;
         cs_in   = '0;
         clr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         in_width_ff   <= 11'd1;
         in_height_ff  <= 12'd1;
         out_width_ff  <= 11'd1;
         out_height_ff <= 12'd1;
         channels_ff   <= 3'd1;
         mono_ff       <= 1'b0;
         divisor_ff    <= 24'd1;
         shift_ff      <= 4'd0;
         vp_ff         <= '0;
         hph_ff        <= '0;
         icol_ff       <= '0;
         ocol_ff       <= '0;
         orow_ff       <= '0;
         bnd_ff        <= 1'b0;
         rem_ff        <= '0;
         n_ff          <= '0;
         clr_ff        <= '0;
         pend_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cs_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         in_width_ff   <= in_width_in;
         in_height_ff  <= in_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         channels_ff   <= channels_in;
         mono_ff       <= mono_in;
         divisor_ff    <= divisor_in;
         shift_ff      <= shift_in;
         vp_ff         <= vp_in;
         hph_ff        <= hph_in;
         icol_ff       <= icol_in;
         ocol_ff       <= ocol_in;
         orow_ff       <= orow_in;
         bnd_ff        <= bnd_in;
         rem_ff        <= rem_in;
         n_ff          <= n_in;
         clr_ff        <= clr_in;
         pend_v_ff     <= pend_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         cs_ff         <= cs_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      wu_ff       <= wu_in;
      wl_ff       <= wl_in;
      pu_ff       <= pu_in;
      pl_ff       <= pl_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   asc_acc_mem #(
      .DEPTH (MAX_OUT_WIDTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (AW'(ocol_ff)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   asc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum),
      .divisor  (div_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_ch0     = rsp_ff.ch[0];
   assign rsp_out_ch1     = rsp_ff.ch[1];
   assign rsp_out_ch2     = rsp_ff.ch[2];
   assign rsp_out_ch3     = rsp_ff.ch[3];
   assign rsp_out_column  = rsp_ff.column;
   assign rsp_out_row     = rsp_ff.row;
   assign rsp_row_end     = rsp_ff.row_end;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("pixel accepted during clearing pass");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");
   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> n_ff < RES_CAP)
      else $error("too many results for one pixel");
   a_read_after_step: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == ST_MAC || state_ff == ST_CLEAR)
      else $error("memory read without accumulate");
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> hph_ff < iw_eff)
      else $error("horizontal phase out of range");
`endif

endmodule
